### design/gn3o_pkg.sv
// Shared types, widths and constants of the octave gradient noise unit.
`timescale 1ns / 1ps

package gn3o_pkg;

  // Lattice table geometry.
  localparam int unsigned TABLE_SIZE  = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
  localparam int unsigned MAX_OCTAVES = 8;

  // Fixed-point formats.
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned GRAD_FRAC_BITS  = 14;
  localparam int unsigned SCALE_FRAC_BITS = 16;
  localparam int unsigned OUT_FRAC_BITS   = 16;

  // Field widths of the words on the ports.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned GRAD_W     = 16;
  localparam int unsigned PERM_W     = 8;
  localparam int unsigned GRAD_ROW_W = 3 * GRAD_W;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned PERS_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Internal datapath widths.
  localparam int unsigned SCALE_W = 31;  // running frequency and amplitude
  localparam int unsigned MA_W    = 32;  // wide multiplier operands
  localparam int unsigned MB_AW   = 36;  // narrow multiplier, wide operand
  localparam int unsigned MB_BW   = 18;  // narrow multiplier, short operand
  localparam int unsigned NV_W    = 22;  // one octave value at Q.16
  localparam int unsigned TOT_W   = 58;  // weighted sum
  localparam int unsigned WSUM_W  = 36;  // sum of weights
  localparam int unsigned DCNT_W  = $clog2(TOT_W);
  localparam int unsigned NOISE_SHIFT = GRAD_FRAC_BITS + COORD_FRAC_BITS - OUT_FRAC_BITS;

  // Fade polynomial constants and the unit coordinate.
  localparam logic signed [MB_AW-1:0] FADE_K15 = MB_AW'(15 * (2 ** COORD_FRAC_BITS));
  localparam logic signed [MB_AW-1:0] FADE_K10 = MB_AW'(10 * (2 ** COORD_FRAC_BITS));
  localparam logic signed [MB_BW-1:0] FRAC_ONE = MB_BW'(2 ** COORD_FRAC_BITS);

  // Saturation bounds of the result.
  localparam logic [TOT_W-1:0] SAT_POS = TOT_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic [TOT_W-1:0] SAT_NEG = TOT_W'(2 ** (OUT_W - 1));
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COORD_MUL,
    ST_COORD_CAP,
    ST_FADE_MUL,
    ST_FADE_CAP,
    ST_HASH_Z,
    ST_HASH_Y,
    ST_HASH_X,
    ST_GRAD_RD,
    ST_DOT,
    ST_RED_MUL,
    ST_RED_ADD,
    ST_OCT_MUL,
    ST_OCT_ACC,
    ST_OCT_NEXT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_FIN
  } st_e;

endpackage

### design/gn3o_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module gn3o_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; the read word holds while idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/gradient_noise_3d_octaves_unit.sv
// Top level of the multi-octave 3-D gradient noise unit.
//
// Input channel (in_valid_i / in_stall_o): a word with command 0 writes one
// permutation entry and its gradient into the lattice tables in the cycle it
// is accepted and gives no result. A word with command 1 evaluates noise at
// the given Q16.16 point and gives one result word.
// Output channel (out_valid_o / out_stall_i): noise_value_o in Q7.16 and the
// zero_weight_o flag. The result sits in an output register, so the next
// input word is taken while an earlier result still waits for the receiver.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high and writes are expected only while the unit is idle.
// Sequence: a load does not stall the input. An evaluation of n octaves holds
// the input stalled until its result is handed to the output register; a
// zero weight sum skips the division. Per octave: coordinate scaling, fade,
// 8 corners (three chained permutation reads, a gradient read, a dot
// product each), blending and weighting. The final division is radix-2.
// Reset clears the sequencer, the output valid and the configuration to its
// defaults; the tables are not cleared and must be loaded before use. A
// stalled receiver holds the result, and a finished evaluation waits for it.
`timescale 1ns / 1ps

module gradient_noise_3d_octaves_unit
  import gn3o_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [IDX_W-1:0]             table_index_i,
  input  logic [PERM_W-1:0]            perm_entry_i,
  input  logic signed [GRAD_W-1:0]     grad_x_i,
  input  logic signed [GRAD_W-1:0]     grad_y_i,
  input  logic signed [GRAD_W-1:0]     grad_z_i,
  input  logic signed [COORD_W-1:0]    coord_x_i,
  input  logic signed [COORD_W-1:0]    coord_y_i,
  input  logic signed [COORD_W-1:0]    coord_z_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_W-1:0]      noise_value_o,
  output logic                         zero_weight_o,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  // Configuration registers.
  logic [CNT_W-1:0]  oct_cnt_q;
  logic [FREQ_W-1:0] base_freq_q;
  logic [FREQ_W-1:0] base_amp_q;
  logic [PERS_W-1:0] persist_q;

  // Sequencer and datapath state.
  st_e                       state_q, state_d;
  logic signed [COORD_W-1:0] coord_q [3];
  logic signed [COORD_W-1:0] coord_d [3];
  logic [CNT_W-1:0]          n_q, n_d, oct_q, oct_d;
  logic [SCALE_W-1:0]        freq_q, freq_d, amp_q, amp_d;
  logic signed [TOT_W-1:0]   total_q, total_d;
  logic [WSUM_W-1:0]         wsum_q, wsum_d;
  logic [1:0]                ax_q, ax_d, fstep_q, fstep_d;
  logic signed [MB_AW-1:0]   fh_q, fh_d;
  logic [IDX_W-1:0]          cell_q [3];
  logic [IDX_W-1:0]          cell_d [3];
  logic [COORD_FRAC_BITS-1:0] frac_q [3];
  logic [COORD_FRAC_BITS-1:0] frac_d [3];
  logic signed [MB_BW-1:0]   fade_q [3];
  logic signed [MB_BW-1:0]   fade_d [3];
  logic [2:0]                corner_q, corner_d;
  logic [1:0]                dk_q, dk_d, lvl_q, lvl_d;
  logic signed [MB_AW-1:0]   dacc_q, dacc_d;
  logic signed [MB_AW-1:0]   stk_q [4];
  logic signed [MB_AW-1:0]   stk_d [4];
  logic [TOT_W-1:0]          quo_q, quo_d;
  logic [WSUM_W:0]           rem_q, rem_d;
  logic [DCNT_W-1:0]         dcnt_q, dcnt_d;
  logic                      neg_q, neg_d;
  logic [OUT_W-1:0]          res_val_q, res_val_d;
  logic                      res_zw_q, res_zw_d;
  logic                      out_valid_q, out_valid_d;
  logic [OUT_W-1:0]          out_val_q, out_val_d;
  logic                      out_zw_q, out_zw_d;

  // Shared multipliers: operands chosen by the sequencer, products registered.
  logic signed [MA_W-1:0]        ma_a, ma_b;
  logic signed [2*MA_W-1:0]      ma_q;
  logic signed [MB_AW-1:0]       mb_a;
  logic signed [MB_BW-1:0]       mb_b;
  logic signed [MB_AW+MB_BW-1:0] mb_q;

  // Table ports.
  logic                   in_accept;
  logic                   tbl_we;
  logic                   perm_re, grad_re;
  logic [IDX_W-1:0]       perm_raddr, grad_raddr;
  logic [PERM_W-1:0]      perm_rdata;
  logic [GRAD_ROW_W-1:0]  grad_rdata;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign tbl_we      = in_accept && (command_i == CMD_LOAD);
  assign cfg_ready_o = 1'b1;

  // Lattice tables.
  gn3o_ram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (table_index_i),
    .wdata_i (perm_entry_i),
    .re_i    (perm_re),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  gn3o_ram #(
    .WIDTH (GRAD_ROW_W),
    .DEPTH (TABLE_SIZE)
  ) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (table_index_i),
    .wdata_i ({grad_z_i, grad_y_i, grad_x_i}),
    .re_i    (grad_re),
    .raddr_i (grad_raddr),
    .rdata_o (grad_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q   <= CNT_W'(1);
      base_freq_q <= FREQ_W'(65536);
      base_amp_q  <= FREQ_W'(65536);
      persist_q   <= PERS_W'(32768);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OCTAVES:     oct_cnt_q   <= cfg_data_i[CNT_W-1:0];
        CFG_BASE_FREQ:   base_freq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_BASE_AMP:    base_amp_q  <= cfg_data_i[FREQ_W-1:0];
        CFG_PERSISTENCE: persist_q   <= cfg_data_i[PERS_W-1:0];
        default:         oct_cnt_q   <= oct_cnt_q;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ma_q      <= ma_a * ma_b;
    mb_q      <= mb_a * mb_b;
    coord_q   <= coord_d;
    n_q       <= n_d;
    oct_q     <= oct_d;
    freq_q    <= freq_d;
    amp_q     <= amp_d;
    total_q   <= total_d;
    wsum_q    <= wsum_d;
    ax_q      <= ax_d;
    fstep_q   <= fstep_d;
    fh_q      <= fh_d;
    cell_q    <= cell_d;
    frac_q    <= frac_d;
    fade_q    <= fade_d;
    corner_q  <= corner_d;
    dk_q      <= dk_d;
    lvl_q     <= lvl_d;
    dacc_q    <= dacc_d;
    stk_q     <= stk_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    neg_q     <= neg_d;
    res_val_q <= res_val_d;
    res_zw_q  <= res_zw_d;
    out_val_q <= out_val_d;
    out_zw_q  <= out_zw_d;
  end

  // Sequencer: next state, multiplier operands, table reads and datapath.
  always_comb begin
    logic signed [MB_AW-1:0]  tz;
    logic signed [MB_AW-1:0]  h0;
    logic signed [MB_AW-1:0]  shifted;
    logic signed [MB_AW-1:0]  dsum;
    logic signed [NV_W-1:0]   nv;
    logic signed [MB_BW-1:0]  diff;
    logic signed [GRAD_W-1:0] gcomp;
    logic [WSUM_W:0]          rem_sh;
    logic                     qbit;

    state_d   = state_q;
    coord_d   = coord_q;
    n_d       = n_q;
    oct_d     = oct_q;
    freq_d    = freq_q;
    amp_d     = amp_q;
    total_d   = total_q;
    wsum_d    = wsum_q;
    ax_d      = ax_q;
    fstep_d   = fstep_q;
    fh_d      = fh_q;
    cell_d    = cell_q;
    frac_d    = frac_q;
    fade_d    = fade_q;
    corner_d  = corner_q;
    dk_d      = dk_q;
    lvl_d     = lvl_q;
    dacc_d    = dacc_q;
    stk_d     = stk_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    neg_d     = neg_q;
    res_val_d = res_val_q;
    res_zw_d  = res_zw_q;
    out_val_d = out_val_q;
    out_zw_d  = out_zw_q;

    // The output word leaves when the receiver takes it.
    out_valid_d = out_valid_q && out_stall_i;

    ma_a       = '0;
    ma_b       = '0;
    mb_a       = '0;
    mb_b       = '0;
    perm_re    = 1'b0;
    grad_re    = 1'b0;
    perm_raddr = '0;
    grad_raddr = perm_rdata;

    tz      = MB_AW'($signed({1'b0, frac_q[ax_q]}));
    h0      = (tz <<< 2) + (tz <<< 1) - FADE_K15;
    shifted = MB_AW'(mb_q >>> COORD_FRAC_BITS);
    dsum    = dacc_q + MB_AW'(mb_q);
    nv      = NV_W'(stk_q[0] >>> NOISE_SHIFT);
    rem_sh  = {rem_q[WSUM_W-1:0], quo_q[TOT_W-1]};
    qbit    = (rem_sh >= {1'b0, wsum_q});

    // Dot product term selected by the axis step.
    case (dk_q)
      2'd0: begin
        gcomp = $signed(grad_rdata[GRAD_W-1:0]);
        diff  = $signed({2'b00, frac_q[0]}) - (corner_q[0] ? FRAC_ONE : '0);
      end
      2'd1: begin
        gcomp = $signed(grad_rdata[2*GRAD_W-1:GRAD_W]);
        diff  = $signed({2'b00, frac_q[1]}) - (corner_q[1] ? FRAC_ONE : '0);
      end
      2'd2: begin
        gcomp = $signed(grad_rdata[3*GRAD_W-1:2*GRAD_W]);
        diff  = $signed({2'b00, frac_q[2]}) - (corner_q[2] ? FRAC_ONE : '0);
      end
      default: begin
        gcomp = '0;
        diff  = '0;
      end
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (command_i == CMD_EVAL)) begin
          coord_d[0] = coord_x_i;
          coord_d[1] = coord_y_i;
          coord_d[2] = coord_z_i;
          n_d        = (oct_cnt_q > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES) : oct_cnt_q;
          oct_d      = '0;
          freq_d     = SCALE_W'(base_freq_q);
          amp_d      = SCALE_W'(base_amp_q);
          total_d    = '0;
          wsum_d     = '0;
          ax_d       = '0;
          state_d    = (n_d == '0) ? ST_DIV_INIT : ST_COORD_MUL;
        end
      end

      // Scale one axis of the point by the running frequency.
      ST_COORD_MUL: begin
        ma_a    = coord_q[ax_q];
        ma_b    = $signed({1'b0, freq_q});
        state_d = ST_COORD_CAP;
      end

      ST_COORD_CAP: begin
        cell_d[ax_q] = ma_q[COORD_FRAC_BITS+SCALE_FRAC_BITS +: IDX_W];
        frac_d[ax_q] = ma_q[SCALE_FRAC_BITS +: COORD_FRAC_BITS];
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          fstep_d = '0;
          state_d = ST_FADE_MUL;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_COORD_MUL;
        end
      end

      // Horner steps of the fade polynomial, four products per axis.
      ST_FADE_MUL: begin
        mb_a    = (fstep_q == 2'd0) ? h0 : fh_q;
        mb_b    = MB_BW'($signed({1'b0, frac_q[ax_q]}));
        state_d = ST_FADE_CAP;
      end

      ST_FADE_CAP: begin
        fh_d = (fstep_q == 2'd0) ? (shifted + FADE_K10) : shifted;
        if (fstep_q == 2'd3) begin
          fade_d[ax_q] = shifted[MB_BW-1:0];
          fstep_d      = '0;
          if (ax_q == 2'd2) begin
            corner_d = '0;
            state_d  = ST_HASH_Z;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = ST_FADE_MUL;
          end
        end else begin
          fstep_d = fstep_q + 2'd1;
          state_d = ST_FADE_MUL;
        end
      end

      // Chained permutation lookups for one corner.
      ST_HASH_Z: begin
        perm_re    = 1'b1;
        perm_raddr = cell_q[2] + IDX_W'(corner_q[2]);
        state_d    = ST_HASH_Y;
      end

      ST_HASH_Y: begin
        perm_re    = 1'b1;
        perm_raddr = cell_q[1] + IDX_W'(corner_q[1]) + perm_rdata;
        state_d    = ST_HASH_X;
      end

      ST_HASH_X: begin
        perm_re    = 1'b1;
        perm_raddr = cell_q[0] + IDX_W'(corner_q[0]) + perm_rdata;
        state_d    = ST_GRAD_RD;
      end

      ST_GRAD_RD: begin
        grad_re = 1'b1;
        dk_d    = '0;
        dacc_d  = '0;
        state_d = ST_DOT;
      end

      // Gradient dot product, one axis per cycle, result pushed on the stack.
      ST_DOT: begin
        mb_a = MB_AW'(diff);
        mb_b = MB_BW'(gcomp);
        if (dk_q != 2'd0) begin
          dacc_d = dsum;
        end
        if (dk_q == 2'd3) begin
          stk_d[0] = dsum;
          stk_d[1] = stk_q[0];
          stk_d[2] = stk_q[1];
          stk_d[3] = stk_q[2];
          if (corner_q[0]) begin
            lvl_d   = '0;
            state_d = ST_RED_MUL;
          end else begin
            corner_d = corner_q + 3'd1;
            state_d  = ST_HASH_Z;
          end
        end else begin
          dk_d = dk_q + 2'd1;
        end
      end

      // Blend the two top stack entries with the fade of the current level.
      ST_RED_MUL: begin
        mb_a    = stk_q[0] - stk_q[1];
        mb_b    = fade_q[lvl_q];
        state_d = ST_RED_ADD;
      end

      ST_RED_ADD: begin
        stk_d[0] = stk_q[1] + shifted;
        stk_d[1] = stk_q[2];
        stk_d[2] = stk_q[3];
        stk_d[3] = stk_q[3];
        if ((lvl_q == 2'd0) && corner_q[1]) begin
          lvl_d   = 2'd1;
          state_d = ST_RED_MUL;
        end else if ((lvl_q == 2'd1) && corner_q[2]) begin
          lvl_d   = 2'd2;
          state_d = ST_RED_MUL;
        end else if (lvl_q == 2'd2) begin
          state_d = ST_OCT_MUL;
        end else begin
          corner_d = corner_q + 3'd1;
          state_d  = ST_HASH_Z;
        end
      end

      // Weight the octave value and step the amplitude.
      ST_OCT_MUL: begin
        ma_a    = MA_W'(nv);
        ma_b    = $signed({1'b0, amp_q});
        state_d = ST_OCT_ACC;
      end

      ST_OCT_ACC: begin
        total_d = total_q + TOT_W'(ma_q);
        wsum_d  = wsum_q + WSUM_W'(amp_q);
        ma_a    = $signed({1'b0, amp_q});
        ma_b    = MA_W'($signed({1'b0, persist_q}));
        state_d = ST_OCT_NEXT;
      end

      ST_OCT_NEXT: begin
        amp_d  = ma_q[16 +: SCALE_W];
        freq_d = freq_q << 1;
        oct_d  = oct_q + CNT_W'(1);
        ax_d   = '0;
        state_d = (oct_d < n_q) ? ST_COORD_MUL : ST_DIV_INIT;
      end

      // Normalize: restoring division of the magnitude, one bit a cycle.
      ST_DIV_INIT: begin
        if (wsum_q == '0) begin
          res_val_d = '0;
          res_zw_d  = 1'b1;
          state_d   = ST_FIN;
        end else begin
          neg_d   = total_q[TOT_W-1];
          quo_d   = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_d  = qbit ? (rem_sh - {1'b0, wsum_q}) : rem_sh;
        quo_d  = {quo_q[TOT_W-2:0], qbit};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(TOT_W - 1)) begin
          state_d = ST_DIV_FIN;
        end
      end

      // Sign and saturation of the quotient.
      ST_DIV_FIN: begin
        res_zw_d = 1'b0;
        if (neg_q) begin
          res_val_d = (quo_q > SAT_NEG) ? OUT_MIN : OUT_W'(-quo_q);
        end else begin
          res_val_d = (quo_q > SAT_POS) ? OUT_MAX : quo_q[OUT_W-1:0];
        end
        state_d = ST_FIN;
      end

      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_zw_d    = res_zw_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = $signed(out_val_q);
  assign zero_weight_o = out_zw_q;

`ifndef ASSERT_OFF
  // A new result only appears from the hand-off state.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the hand-off state");

  // A zero weight sum always carries a zero value.
  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_weight_o) |-> (noise_value_o == '0))
    else $error("zero weight result with nonzero value");

  // Tables are never written while an evaluation reads them.
  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> ((state_q == ST_IDLE) && !perm_re && !grad_re))
    else $error("table write during an evaluation");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench of the multi-octave 3-D gradient noise unit.
`timescale 1ns / 1ps

module tb_top;
  import gn3o_pkg::*;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [7:0]              addr;      // register index or table index
    logic [23:0]             data;      // register value or permutation entry
    logic signed [GRAD_W-1:0]  gx, gy, gz;
    logic signed [COORD_W-1:0] cx, cy, cz;
    bit                      zero_row;  // result is known to be the zero-weight word
  } dir_row_t;

  typedef struct {
    logic signed [OUT_W-1:0] noise;
    logic                    zw;
  } noise_word_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, command_i;
  logic [IDX_W-1:0] table_index_i;
  logic [PERM_W-1:0] perm_entry_i;
  logic signed [GRAD_W-1:0] grad_x_i, grad_y_i, grad_z_i;
  logic signed [COORD_W-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic out_valid_o, out_stall_i;
  logic signed [OUT_W-1:0] noise_value_o;
  logic zero_weight_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gradient_noise_3d_octaves_unit dut (.*);

  // Shadow copy of the lattice tables and the settings.
  logic [7:0] perm_mem [TABLE_SIZE];
  longint     grad_mem [TABLE_SIZE][3];
  longint unsigned octaves_q, freq_q, amp_q, pers_q;

  noise_word_t noise_exp_q[$];
  dir_row_t    dir_rows[$];
  int err_count  = 0;
  int words_sent = 0;
  int tx_pct, rx_pct;
  bit hold_req  = 0;
  bit hold_done = 0;
  int hold_cnt  = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(64'd400_000_000);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic longint fade_curve(longint t);
    longint h;
    h = 6 * t - (longint'(15) <<< COORD_FRAC_BITS);
    h = ((t * h) >>> COORD_FRAC_BITS) + (longint'(10) <<< COORD_FRAC_BITS);
    h = (t * h) >>> COORD_FRAC_BITS;
    h = (t * h) >>> COORD_FRAC_BITS;
    h = (t * h) >>> COORD_FRAC_BITS;
    return h;
  endfunction

  function automatic longint lerp_q(longint t, longint a, longint b);
    return a + (((b - a) * t) >>> COORD_FRAC_BITS);
  endfunction

  // Noise of one octave at a lattice cube and fraction, at Q.30.
  function automatic longint octave_noise(longint unsigned lat_pos[3], longint frac[3]);
    longint d[8];
    longint unsigned h;
    longint u, v, w;
    int bx, by, bz;
    for (int c = 0; c < 8; c++) begin
      bx = c & 1;
      by = (c >> 1) & 1;
      bz = (c >> 2) & 1;
      h = perm_mem[(lat_pos[2] + bz) & (TABLE_SIZE - 1)];
      h = perm_mem[(lat_pos[1] + by + h) & (TABLE_SIZE - 1)];
      h = perm_mem[(lat_pos[0] + bx + h) & (TABLE_SIZE - 1)];
      d[c] = grad_mem[h][0] * (frac[0] - (bx << COORD_FRAC_BITS))
           + grad_mem[h][1] * (frac[1] - (by << COORD_FRAC_BITS))
           + grad_mem[h][2] * (frac[2] - (bz << COORD_FRAC_BITS));
    end
    u = fade_curve(frac[0]);
    v = fade_curve(frac[1]);
    w = fade_curve(frac[2]);
    return lerp_q(w, lerp_q(v, lerp_q(u, d[0], d[1]), lerp_q(u, d[2], d[3])),
                     lerp_q(v, lerp_q(u, d[4], d[5]), lerp_q(u, d[6], d[7])));
  endfunction

  // Normalized octave sum at a Q16.16 point under the current settings.
  function automatic noise_word_t fbm_noise(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] pz);
    noise_word_t r;
    longint unsigned n, amp, freq, p;
    longint unsigned lat_pos[3];
    longint frac[3];
    longint coord[3];
    longint total, wsum, q;
    coord[0] = px;
    coord[1] = py;
    coord[2] = pz;
    n = (octaves_q > MAX_OCTAVES) ? MAX_OCTAVES : octaves_q;
    amp = amp_q;
    total = 0;
    wsum = 0;
    for (int i = 0; i < n; i++) begin
      freq = freq_q << i;
      for (int k = 0; k < 3; k++) begin
        p = longint'(unsigned'(coord[k])) * freq;
        lat_pos[k] = (p >> (COORD_FRAC_BITS + SCALE_FRAC_BITS)) & (TABLE_SIZE - 1);
        frac[k] = (p >> SCALE_FRAC_BITS) & 64'hFFFF;
      end
      total += (octave_noise(lat_pos, frac) >>> NOISE_SHIFT) * longint'(amp);
      wsum += longint'(amp);
      amp = (amp * pers_q) >> 16;
    end
    if (wsum == 0) begin
      r.noise = '0;
      r.zw = 1'b1;
    end else begin
      q = total / wsum;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      r.noise = q[OUT_W-1:0];
      r.zw = 1'b0;
    end
    return r;
  endfunction

  // Waits until every result is back and the unit has settled.
  task automatic wait_drained();
    while (noise_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes one configuration register while the unit is idle.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OCTAVES:     octaves_q = val & 24'hF;
      CFG_BASE_FREQ:   freq_q    = val;
      CFG_BASE_AMP:    amp_q     = val;
      CFG_PERSISTENCE: pers_q    = val & 24'h1FFFF;
      default: ;
    endcase
  endtask

  // Offers one input word and records what it should produce.
  task automatic send_word(dir_row_t w);
    noise_word_t zero_word;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= (w.kind == ROW_EVAL) ? CMD_EVAL : CMD_LOAD;
    table_index_i <= w.addr;
    perm_entry_i  <= w.data[7:0];
    grad_x_i      <= w.gx;
    grad_y_i      <= w.gy;
    grad_z_i      <= w.gz;
    coord_x_i     <= w.cx;
    coord_y_i     <= w.cy;
    coord_z_i     <= w.cz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (words_sent == 500) hold_req = 1'b1;
    if (w.kind == ROW_LOAD) begin
      perm_mem[w.addr]    = w.data[7:0];
      grad_mem[w.addr][0] = w.gx;
      grad_mem[w.addr][1] = w.gy;
      grad_mem[w.addr][2] = w.gz;
    end else if (w.zero_row) begin
      zero_word.noise = '0;
      zero_word.zw = 1'b1;
      noise_exp_q.push_back(zero_word);
    end else begin
      noise_exp_q.push_back(fbm_noise(w.cx, w.cy, w.cz));
    end
  endtask

  function automatic dir_row_t random_word();
    dir_row_t w;
    w.kind = ($urandom_range(0, 99) < 60) ? ROW_EVAL : ROW_LOAD;
    w.addr = 8'($urandom);
    w.data = 24'($urandom);
    w.gx = 16'($urandom);
    w.gy = 16'($urandom);
    w.gz = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      w.cx = $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
      w.cy = $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
      w.cz = $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
    end else begin
      w.cx = $urandom;
      w.cy = $urandom;
      w.cz = $urandom;
    end
    w.zero_row = 1'b0;
    return w;
  endfunction

  function automatic dir_row_t mk_row(row_kind_e kind, logic [7:0] addr, logic [23:0] data,
                                      logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                      logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                      bit zero_row);
    dir_row_t r;
    r = '{kind, addr, data, gx, gy, gz, cx, cy, cz, zero_row};
    return r;
  endfunction

  // Receiver: stalls at random, holds off once for a long stretch, checks results.
  always @(posedge clk_i) begin
    noise_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (noise_exp_q.size() == 0) begin
        report_mismatch("unexpected result", noise_value_o, 0);
      end else begin
        want = noise_exp_q.pop_front();
        if (noise_value_o !== want.noise) report_mismatch("noise_value", noise_value_o, want.noise);
        if (zero_weight_o !== want.zw) report_mismatch("zero_weight", zero_weight_o, want.zw);
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 4000;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // Main stimulus sequence.
  initial begin
    dir_row_t w;
    int oct;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_LOAD;
    table_index_i = '0;
    perm_entry_i = '0;
    grad_x_i = '0;
    grad_y_i = '0;
    grad_z_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    tx_pct = 27;
    rx_pct = 78;
    octaves_q = 1;
    freq_q = 65536;
    amp_q = 65536;
    pers_q = 32768;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every table entry before anything is evaluated.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      w = random_word();
      w.kind = ROW_LOAD;
      w.addr = 8'(i);
      send_word(w);
    end

    // Directed rows: reset settings, field extremes and each special case.
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                              32'h80000000, 0));
    dir_rows.push_back(mk_row(ROW_LOAD, 0, 255, 16'h7FFF, 16'h8000, 16'h4000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_LOAD, 255, 0, 16'h8000, 16'h7FFF, 16'hC000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_OCTAVES, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00018000, 32'h1234, 32'h5, 1));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_OCTAVES, 15, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_PERSISTENCE, 24'h1FFFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00028000, 32'hFFFE4000,
                              32'h00007FFF, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_PERSISTENCE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00013000, 32'h00021000,
                              32'h00031000, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_FREQ, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_AMP, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_PERSISTENCE, 65536, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                              32'h00000001, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_FREQ, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00050000, 32'h1, 32'hFFFF0000, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_AMP, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00050000, 32'h1, 32'h2, 1));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_OCTAVES, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_AMP, 65536, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_CFG, CFG_BASE_FREQ, 65536, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 0, 0, 32'h00038000, 32'h00014000,
                              32'hFFFF2000, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_setting(dir_rows[i].addr[CFG_IDX_W-1:0], dir_rows[i].data);
      end else begin
        send_word(dir_rows[i]);
      end
    end

    // Random phases, each under a fresh random setting.
    for (int ph = 0; ph < 8; ph++) begin
      oct = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3);
      write_setting(CFG_OCTAVES, 24'(oct));
      write_setting(CFG_BASE_FREQ, ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'h10000);
      write_setting(CFG_BASE_AMP, ($urandom_range(0, 7) == 0) ? 24'h0 : 24'($urandom));
      write_setting(CFG_PERSISTENCE, 24'($urandom_range(0, 131071)));
      for (int i = 0; i < 250; i++) begin
        if (words_sent > 1500) begin
          tx_pct = 0;
          rx_pct = 0;
        end else if (words_sent > 900) begin
          tx_pct = 78;
          rx_pct = 27;
        end
        send_word(random_word());
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
